>>> rtl/core/lsra_pkg.sv
package lsra_pkg;

  // Width of a register number on the result side
  localparam int REG_W = 6;
  // Result tdata width, padded to whole bytes
  localparam int OUT_W = ((REG_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_COMPACT,
    ST_POP,
    ST_ALLOC
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_run;
    logic count_en;
    logic compact_en;
    logic commit;
    logic pop;
    logic alloc;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/lsra_ram.sv
module lsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lsra_ctrl.sv
module lsra_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lsra_pkg::stat_t stat,
  output lsra_pkg::cmd_t  cmd
);

  import lsra_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (stat.scan_done) begin
          state_nxt = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        if (stat.scan_done) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        state_nxt = ST_ALLOC;
      end
      ST_ALLOC: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load      = 1'b1;
          cmd.scan_init = 1'b1;
        end
      end
      ST_COUNT: begin
        cmd.scan_run = 1'b1;
        cmd.count_en = 1'b1;
        if (stat.scan_done) begin
          cmd.scan_init = 1'b1;
        end
      end
      ST_COMPACT: begin
        cmd.scan_run   = 1'b1;
        cmd.compact_en = 1'b1;
        if (stat.scan_done) begin
          cmd.commit = 1'b1;
        end
      end
      ST_POP: begin
        cmd.pop = 1'b1;
      end
      ST_ALLOC: begin
        if (stat.out_free) begin
          cmd.alloc = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/lsra_dp.sv
module lsra_dp #(
  parameter int MAX_ACTIVE = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lsra_pkg::cmd_t              cmd,
  output lsra_pkg::stat_t             stat,
  input  logic                        first_of_run,
  input  logic [INDEX_BITS-1:0]       interval_start,
  input  logic [INDEX_BITS-1:0]       interval_end,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [lsra_pkg::REG_W-1:0]  assigned_register,
  output logic                        overflow
);

  import lsra_pkg::*;

  localparam int AW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int CW = $clog2(MAX_ACTIVE + 1);
  localparam int PW = CW + 1;
  localparam int EW = INDEX_BITS + REG_W;

  // Control state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] fc_r, fc_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Per-interval working registers
  logic [INDEX_BITS-1:0] start_r, start_nxt;
  logic [INDEX_BITS-1:0] end_r, end_nxt;
  logic [CW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         exp_r, exp_nxt;
  logic [CW-1:0]         rank_r, rank_nxt;
  logic [CW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic                  popped_r, popped_nxt;
  logic [REG_W-1:0]      out_reg_r, out_reg_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // Memory ports
  logic             act_we, act_re;
  logic [AW-1:0]    act_waddr;
  logic [EW-1:0]    act_wdata, act_q;
  logic             fr_we, fr_re;
  logic [AW-1:0]    fr_waddr, fr_raddr;
  logic [REG_W-1:0] fr_q;

  logic [INDEX_BITS-1:0] q_end;
  logic [REG_W-1:0]      q_reg;
  logic                  expired;
  logic [PW-1:0]         push_pos;
  logic [PW-1:0]         fc_sum;
  logic                  ovf;
  logic [REG_W+CW-1:0]   cnt_ext;
  logic [REG_W-1:0]      new_reg;

  assign q_end   = act_q[EW-1:REG_W];
  assign q_reg   = act_q[REG_W-1:0];
  assign expired = (q_end <= start_r);
  assign ovf     = (cnt_r >= CW'(MAX_ACTIVE));
  assign cnt_ext = {{REG_W{1'b0}}, cnt_r};
  assign new_reg = popped_r ? fr_q : cnt_ext[REG_W-1:0];

  // Expired entries land on the stack so that the highest index is pushed first
  assign push_pos = {1'b0, fc_r} + {1'b0, exp_r} - PW'(1) - {1'b0, rank_r};
  assign fc_sum   = {1'b0, fc_r} + {1'b0, exp_r};

  // Status
  assign stat.scan_done = (rd_ptr_r == cnt_r) && !rd_vld_r;
  assign stat.out_free  = !out_valid_r || out_tready;

  // Active list read: one entry per cycle in ascending order
  assign act_re = cmd.scan_run && !cmd.scan_init && (rd_ptr_r < cnt_r);

  // Active list write: keep a survivor during compaction, or append
  always_comb begin
    act_we    = 1'b0;
    act_waddr = wr_ptr_r[AW-1:0];
    act_wdata = act_q;
    if (cmd.compact_en && rd_vld_r && !expired) begin
      act_we = 1'b1;
    end else if (cmd.alloc && !ovf) begin
      act_we    = 1'b1;
      act_waddr = cnt_r[AW-1:0];
      act_wdata = {end_r, new_reg};
    end
  end

  // Free stack: push during compaction, drop pushes beyond its depth
  assign fr_we    = cmd.compact_en && rd_vld_r && expired && (push_pos < PW'(MAX_ACTIVE));
  assign fr_waddr = push_pos[AW-1:0];
  assign fr_re    = cmd.pop && !ovf && (fc_r != '0);
  assign fr_raddr = fc_r[AW-1:0] - AW'(1);

  // Next values
  always_comb begin
    cnt_nxt       = cnt_r;
    fc_nxt        = fc_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    rd_ptr_nxt    = rd_ptr_r;
    exp_nxt       = exp_r;
    rank_nxt      = rank_r;
    wr_ptr_nxt    = wr_ptr_r;
    popped_nxt    = popped_r;
    out_reg_nxt   = out_reg_r;
    out_ovf_nxt   = out_ovf_r;

    // Capture the transaction, clear the run on its first interval
    if (cmd.load) begin
      start_nxt = interval_start;
      end_nxt   = interval_end;
      exp_nxt   = '0;
      if (first_of_run) begin
        cnt_nxt = '0;
        fc_nxt  = '0;
      end
    end

    // Advance the scan pointer
    if (cmd.scan_init) begin
      rd_ptr_nxt = '0;
      rank_nxt   = '0;
      wr_ptr_nxt = '0;
    end else if (act_re) begin
      rd_ptr_nxt = rd_ptr_r + CW'(1);
      rd_vld_nxt = 1'b1;
    end

    // First pass: count expired entries
    if (cmd.count_en && rd_vld_r && expired) begin
      exp_nxt = exp_r + CW'(1);
    end

    // Second pass: compact survivors, rank expired ones
    if (cmd.compact_en && rd_vld_r) begin
      if (expired) begin
        rank_nxt = rank_r + CW'(1);
      end else begin
        wr_ptr_nxt = wr_ptr_r + CW'(1);
      end
    end

    // Shrink the list and grow the stack, saturating at its depth
    if (cmd.commit) begin
      cnt_nxt = cnt_r - exp_r;
      fc_nxt  = (fc_sum > PW'(MAX_ACTIVE)) ? CW'(MAX_ACTIVE) : fc_sum[CW-1:0];
    end

    // Pop the top of the free stack
    if (cmd.pop) begin
      popped_nxt = fr_re;
      if (fr_re) begin
        fc_nxt = fc_r - CW'(1);
      end
    end

    // Append and load the result register
    if (cmd.alloc) begin
      out_valid_nxt = 1'b1;
      out_ovf_nxt   = ovf;
      out_reg_nxt   = ovf ? '0 : new_reg;
      if (!ovf) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      fc_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      fc_r        <= fc_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r   <= start_nxt;
    end_r     <= end_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    exp_r     <= exp_nxt;
    rank_r    <= rank_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    popped_r  <= popped_nxt;
    out_reg_r <= out_reg_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  lsra_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_ACTIVE)
  ) u_active (
    .clk  (clk),
    .we   (act_we),
    .waddr(act_waddr),
    .wdata(act_wdata),
    .re   (act_re),
    .raddr(rd_ptr_r[AW-1:0]),
    .rdata(act_q)
  );

  lsra_ram #(
    .WIDTH(REG_W),
    .DEPTH(MAX_ACTIVE)
  ) u_free (
    .clk  (clk),
    .we   (fr_we),
    .waddr(fr_waddr),
    .wdata(q_reg),
    .re   (fr_re),
    .raddr(fr_raddr),
    .rdata(fr_q)
  );

  assign out_tvalid        = out_valid_r;
  assign assigned_register = out_reg_r;
  assign overflow          = out_ovf_r;

  // The list and the stack never grow past their depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ACTIVE))
    else $error("active count beyond depth");

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CW'(MAX_ACTIVE))
    else $error("free count beyond depth");

  // A survivor is never written past the old end of the list
  a_compact_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.compact_en && rd_vld_r && !expired) |-> (wr_ptr_r < cnt_r))
    else $error("compaction write beyond list");

  // A recorded interval grows the list by exactly one
  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.alloc && !ovf) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("append did not grow the list");

endmodule

>>> rtl/core/linear_scan_register_allocator.sv
// Each interval is taken in IDLE, then passes through COUNT, COMPACT, POP and ALLOC.
// The active list held before the interval is swept through the single read port of
// the active-list RAM, once to count expiries and once to compact; with first_of_run
// set it is emptied first. A new interval is accepted only back in IDLE.
// Reset: rst_n synchronous, active low; empties the active list and the free stack
// at once, no clearing pass.
module linear_scan_register_allocator #(
  parameter int MAX_ACTIVE = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [INDEX_BITS-1:0] interval_start, [2*INDEX_BITS-1:INDEX_BITS] interval_end
  input  logic [((2*INDEX_BITS+7)/8)*8-1:0] in_tdata,
  // [0] first_of_run
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [5:0] assigned_register
  output logic [lsra_pkg::OUT_W-1:0]     out_tdata,
  // [0] overflow
  output logic                           out_tuser
);

  import lsra_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  logic [REG_W-1:0] assigned_register;

  lsra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsra_dp #(
    .MAX_ACTIVE(MAX_ACTIVE),
    .INDEX_BITS(INDEX_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .first_of_run     (in_tuser),
    .interval_start   (in_tdata[INDEX_BITS-1:0]),
    .interval_end     (in_tdata[2*INDEX_BITS-1:INDEX_BITS]),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .assigned_register(assigned_register),
    .overflow         (out_tuser)
  );

  // Pad the register number to whole bytes
  assign out_tdata = {{(OUT_W-REG_W){1'b0}}, assigned_register};

endmodule

>>> verif/linear_scan_register_allocator_tb.sv
`timescale 1ns / 100ps

module linear_scan_register_allocator_tb;
  import lsra_pkg::*;

  localparam int MAX_ACTIVE  = 64;
  localparam int INDEX_BITS  = 16;
  localparam int IN_W        = ((2 * INDEX_BITS + 7) / 8) * 8;
  localparam int ITEM_TARGET = 1850;
  localparam int STALL_LIMIT = 8000;
  localparam int TAIL_CYCLES = 300;
  localparam int MAX_PRINTS  = 20;

  // One pending live interval plus its pacing
  typedef struct {
    logic                  first_of_run;
    logic [INDEX_BITS-1:0] live_start;
    logic [INDEX_BITS-1:0] live_end;
    int                    gap;
    bit                    drain;
  } interval_t;

  // One expected allocation result
  typedef struct {
    logic [REG_W-1:0] phys_reg;
    logic             overflow;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;

  interval_t intervals_q[$];
  grant_t    grants_q[$];

  // Allocator mirror: ordered active list and LIFO free stack
  logic [INDEX_BITS-1:0] live_ends[MAX_ACTIVE];
  logic [REG_W-1:0]      live_regs[MAX_ACTIVE];
  int                    live_cnt = 0;
  logic [REG_W-1:0]      free_regs[MAX_ACTIVE];
  int                    free_cnt = 0;

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_ovf = 0;
  int n_runs = 0;
  int deepest = 0;
  int quiet_cycles = 0;

  logic      in_taken = 1'b0;
  bit        have_item = 0;
  interval_t staged;
  int        gap_left = 0;
  int        rx_stall_left = 0;
  int        rx_phase_left = 0;
  bit        rx_calm = 0;
  grant_t    got_grant;
  grant_t    want_grant;

  linear_scan_register_allocator #(
    .MAX_ACTIVE(MAX_ACTIVE),
    .INDEX_BITS(INDEX_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 200);
  endfunction

  function automatic logic [INDEX_BITS-1:0] clamp_index(int v);
    if (v > (1 << INDEX_BITS) - 1) return '1;
    return v[INDEX_BITS-1:0];
  endfunction

  task automatic add_interval(input logic first, input int s, input int e, input int gap,
                              input bit drain);
    interval_t it;
    it.first_of_run = first;
    it.live_start   = clamp_index(s);
    it.live_end     = clamp_index(e);
    it.gap          = gap;
    it.drain        = drain;
    intervals_q.push_back(it);
  endtask

  // Expire ended intervals from last to first, then pop or mint a register
  function automatic grant_t allocate_interval(input logic first,
                                               input logic [INDEX_BITS-1:0] s,
                                               input logic [INDEX_BITS-1:0] e);
    grant_t g;
    int     i;
    int     k;
    if (first) begin
      live_cnt = 0;
      free_cnt = 0;
    end
    i = live_cnt;
    while (i > 0) begin
      i--;
      if (live_ends[i] <= s) begin
        if (free_cnt < MAX_ACTIVE) begin
          free_regs[free_cnt] = live_regs[i];
          free_cnt++;
        end
        for (k = i; k + 1 < live_cnt; k++) begin
          live_ends[k] = live_ends[k + 1];
          live_regs[k] = live_regs[k + 1];
        end
        live_cnt--;
      end
    end
    g.phys_reg = '0;
    g.overflow = 1'b1;
    if (live_cnt < MAX_ACTIVE) begin
      g.overflow = 1'b0;
      if (free_cnt > 0) begin
        free_cnt--;
        g.phys_reg = free_regs[free_cnt];
      end else begin
        g.phys_reg = live_cnt[REG_W-1:0];
      end
      live_ends[live_cnt] = e;
      live_regs[live_cnt] = g.phys_reg;
      live_cnt++;
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH result %0d: %s expected %0d got %0d", n_out, what, want, got);
  endtask

  // Stimulus, reset and end of run
  initial begin
    int  total;
    int  kind;
    int  run_len;
    int  cur;
    int  dur;
    int  r;
    bit  calm;

    // Directed: empty state after reset, exact-end expiry, stack order,
    // unsorted and inverted intervals, mid-run restart, index extremes
    add_interval(1'b0, 0, 0, idle_len(), 0);
    add_interval(1'b0, 0, 65535, idle_len(), 0);
    add_interval(1'b0, 1, 5, idle_len(), 0);
    add_interval(1'b0, 2, 3, idle_len(), 0);
    add_interval(1'b0, 3, 10, idle_len(), 0);
    add_interval(1'b0, 5, 7, idle_len(), 0);
    add_interval(1'b0, 6, 9, idle_len(), 0);
    add_interval(1'b0, 100, 100, idle_len(), 0);
    add_interval(1'b0, 50, 40, idle_len(), 0);
    add_interval(1'b0, 40, 20, idle_len(), 0);
    add_interval(1'b1, 65535, 65535, idle_len(), 0);
    add_interval(1'b0, 65535, 0, idle_len(), 0);
    add_interval(1'b0, 65535, 65535, idle_len(), 0);
    add_interval(1'b1, 0, 65535, idle_len(), 0);
    add_interval(1'b0, 0, 65535, 0, 0);
    add_interval(1'b0, 0, 0, 0, 0);
    add_interval(1'b0, 32768, 43690, 0, 0);
    add_interval(1'b0, 21845, 65534, 0, 0);
    // Hold off until the block has answered everything so far
    add_interval(1'b0, 65535, 65535, 0, 1);
    add_interval(1'b1, 65534, 1, idle_len(), 0);
    total = 20;

    // Random runs: mostly sorted runs, some dense runs that fill the list, some noise
    while (total < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      calm = ($urandom_range(0, 4) == 0);
      if (kind < 15) begin
        run_len = $urandom_range(1, 12);
        for (int n = 0; n < run_len; n++) begin
          add_interval($urandom_range(0, 7) == 0, $urandom & 16'hffff, $urandom & 16'hffff,
                       calm ? 0 : idle_len(), $urandom_range(0, 99) == 0);
          total++;
        end
      end else begin
        run_len = (kind < 27) ? $urandom_range(64, 78) : $urandom_range(1, 120);
        cur = (kind < 27) ? $urandom_range(0, 30000) : $urandom_range(0, 65000);
        for (int n = 0; n < run_len; n++) begin
          if (kind < 27) begin
            dur = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(5000, 30000);
          end else begin
            r = $urandom_range(0, 99);
            if (r < 70) dur = $urandom_range(0, 30);
            else if (r < 90) dur = $urandom_range(30, 300);
            else dur = $urandom_range(300, 5000);
          end
          add_interval(n == 0, cur, cur + dur, calm ? 0 : idle_len(),
                       $urandom_range(0, 199) == 0);
          total++;
          cur = cur + (($urandom_range(0, 19) == 0) ? $urandom_range(5, 200)
                                                    : $urandom_range(0, 3));
        end
        // Sometimes close a run with a late start that frees everything
        if ($urandom_range(0, 3) == 0) begin
          add_interval(1'b0, 65535, $urandom & 16'hffff, calm ? 0 : idle_len(), 0);
          total++;
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (intervals_q.size() != 0 || have_item || in_tvalid || grants_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (grants_q.size() != 0) report_mismatch("results left waiting", 0, grants_q.size());

    $display("covered %0d intervals in %0d runs, %0d results, %0d overflows", n_in, n_runs,
             n_out, n_ovf);
    $display("active list reached %0d entries, %0d mismatches", deepest, errors);
    if (errors == 0) begin
      $display("linear_scan_register_allocator_tb OK");
    end else begin
      $display("linear_scan_register_allocator_tb NOT OK");
    end
    $finish;
  end

  // Drive intervals at the falling edge; hold a transaction until accepted
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_taken) have_item = 0;
      if (!(in_tvalid && !in_taken)) begin
        if (!have_item && intervals_q.size() != 0) begin
          staged    = intervals_q.pop_front();
          have_item = 1;
          gap_left  = staged.gap;
        end
        if (have_item && gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (have_item && staged.drain && grants_q.size() != 0) begin
          in_tvalid <= 1'b0;
        end else if (have_item) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {staged.live_end, staged.live_start};
          in_tuser  <= staged.first_of_run;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure: calm phases alternate with random stalls
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_calm       = ($urandom_range(0, 3) == 0);
      rx_phase_left = $urandom_range(50, 400);
    end else begin
      rx_phase_left--;
    end
    if (rx_calm) begin
      out_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else begin
      rx_stall_left = idle_len();
      out_tready <= 1'b1;
    end
  end

  // Predict on each accepted interval, check each accepted result
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      grants_q.push_back(allocate_interval(in_tuser, in_tdata[INDEX_BITS-1:0],
                                           in_tdata[2*INDEX_BITS-1:INDEX_BITS]));
      n_in++;
      if (in_tuser) n_runs++;
      if (live_cnt > deepest) deepest = live_cnt;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_grant.phys_reg = out_tdata[REG_W-1:0];
      got_grant.overflow = out_tuser;
      if (grants_q.size() == 0) begin
        report_mismatch("unexpected result, register", -1, got_grant.phys_reg);
      end else begin
        want_grant = grants_q.pop_front();
        if (got_grant.phys_reg !== want_grant.phys_reg)
          report_mismatch("assigned_register", want_grant.phys_reg, got_grant.phys_reg);
        if (got_grant.overflow !== want_grant.overflow)
          report_mismatch("overflow", want_grant.overflow, got_grant.overflow);
        if (out_tdata[OUT_W-1:REG_W] !== '0)
          report_mismatch("tdata padding", 0, out_tdata[OUT_W-1:REG_W]);
        if (want_grant.overflow) n_ovf++;
      end
      n_out++;
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results waiting", quiet_cycles,
               grants_q.size());
      $display("linear_scan_register_allocator_tb NOT OK");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/core/lsra_pkg.sv
rtl/core/lsra_ram.sv
rtl/core/lsra_ctrl.sv
rtl/core/lsra_dp.sv
rtl/core/linear_scan_register_allocator.sv
verif/linear_scan_register_allocator_tb.sv
